>>> hdl/cit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cit_pkg;
  localparam int unsigned SCORE_MAX = 65535;
  localparam logic [17:0] TERM_NUM = 18'd131072;

  localparam logic [1:0] RK_OBS   = 2'd0;
  localparam logic [1:0] RK_ENTRY = 2'd1;
  localparam logic [1:0] RK_EMPTY = 2'd2;

  localparam logic [1:0] CFG_NEAR  = 2'd0;
  localparam logic [1:0] CFG_TIGHT = 2'd1;
  localparam logic [1:0] CFG_CROWD = 2'd2;
  localparam logic [1:0] CFG_COLOR = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SC_RD,   // read entry for crowding pass
    ST_SC_SQ,   // start square root
    ST_SC_WSQ,  // wait square root
    ST_SC_WDV,  // wait divider
    ST_MT_RD,   // read entry for match pass
    ST_MT_CHK,  // compare and overwrite
    ST_APPEND,
    ST_OBS_OUT,
    ST_CP_RD,   // compaction read
    ST_CP_WR,
    ST_LS_RD,   // listing read
    ST_LS_OUT,
    ST_EMPTY_OUT
  } state_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [11:0] r;
    logic [11:0] g;
    logic [11:0] b;
    logic [15:0] ident;
  } entry_t;
endpackage
`default_nettype wire

>>> hdl/cluster_identity_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// Tracks up to MAX_ENTRIES objects by position and color. For an observation,
// a crowding pass first walks the stored entries, running a 17-step square root
// and an 18-step division on one shared serial unit for each entry (skipped when
// x or z coincide); then a second table walk does the match, and an unmatched
// observation is appended. An end of frame compacts the table and then lists
// each survivor. The table is a memory with a registered read; there is no
// clearing pass. The block takes one request at a time and is not ready until
// the last result has been taken.
module cluster_identity_tracker #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [15:0] in_pos_x,
  input  wire logic [15:0] in_pos_y,
  input  wire logic [15:0] in_pos_z,
  input  wire logic [11:0] in_red,
  input  wire logic [11:0] in_green,
  input  wire logic [11:0] in_blue,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_result_kind,
  output logic [15:0]      out_person_id,
  output logic [15:0]      out_out_x,
  output logic [15:0]      out_out_y,
  output logic [15:0]      out_out_z,
  output logic             out_is_new,
  output logic [4:0]       out_match_count,
  output logic             out_dropped,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_ENTRIES);

  cit_pkg::state_t state_r, state_nxt;

  logic [15:0] near_r, tight_r, crowd_r;
  logic [23:0] color_r;

  cit_pkg::entry_t mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] seen_r, seen_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0] nid_r, nid_nxt;
  logic frame_r, frame_nxt;

  cit_pkg::entry_t obs_r, obs_nxt;
  cit_pkg::entry_t rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  cit_pkg::entry_t wr_data;

  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic [16:0] score_r, score_nxt;
  logic [4:0]  mcnt_r, mcnt_nxt;
  logic [15:0] fid_r, fid_nxt;
  logic        crowded_r, crowded_nxt;

  logic        su_sqrt, su_div, su_busy;
  logic [32:0] su_op;
  logic [17:0] su_res;

  logic        ov_r, ov_nxt;
  logic [1:0]  ok_r, ok_nxt;
  logic [15:0] oid_r, oid_nxt, ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic        onew_r, onew_nxt, odrop_r, odrop_nxt, olast_r, olast_nxt;
  logic [4:0]  ocnt_r, ocnt_nxt;

  // The appending step sets appended_r so the answer can report new or dropped.
  logic appended_r, dropped_r;

  // Distance and color arithmetic against the registered entry.
  logic signed [16:0] dx, dz;
  logic [32:0] d2;
  logic signed [12:0] cr, cg, cb;
  logic [25:0] cd;
  logic [31:0] r2;
  logic        dist_ok, match;
  logic [CW-1:0] idx_inc;

  assign dx = $signed({obs_r.x[15], obs_r.x}) - $signed({rd_q.x[15], rd_q.x});
  assign dz = $signed({obs_r.z[15], obs_r.z}) - $signed({rd_q.z[15], rd_q.z});
  assign d2 = {1'b0, 32'(dx * dx)} + {1'b0, 32'(dz * dz)};
  assign cr = $signed({1'b0, obs_r.r}) - $signed({1'b0, rd_q.r});
  assign cg = $signed({1'b0, obs_r.g}) - $signed({1'b0, rd_q.g});
  assign cb = $signed({1'b0, obs_r.b}) - $signed({1'b0, rd_q.b});
  assign cd = {2'b00, 24'(cr * cr)} + {2'b00, 24'(cg * cg)} + {2'b00, 24'(cb * cb)};
  assign r2 = crowded_r ? tight_r * tight_r : near_r * near_r;
  assign dist_ok = d2 < {1'b0, r2};
  assign match = dist_ok && (!crowded_r || (cd < {2'b00, color_r}));
  assign idx_inc = idx_r + CW'(1);

  cit_seq_unit u_unit (
    .clk, .rst_n,
    .start_sqrt(su_sqrt), .start_div(su_div), .operand(su_op),
    .busy(su_busy), .result(su_res)
  );

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  assign in_ready  = (state_r == cit_pkg::ST_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cit_pkg::ST_IDLE:
        if (in_valid && in_ready) begin
          if (!in_kind) state_nxt = (count_r == '0) ? cit_pkg::ST_APPEND
                                                     : cit_pkg::ST_SC_RD;
          else if (!frame_r) state_nxt = cit_pkg::ST_EMPTY_OUT;
          else state_nxt = cit_pkg::ST_CP_RD;
        end
      cit_pkg::ST_SC_RD:  state_nxt = cit_pkg::ST_SC_SQ;
      cit_pkg::ST_SC_SQ:
        if (dx == '0 || dz == '0)
          state_nxt = (idx_inc == count_r) ? cit_pkg::ST_MT_RD : cit_pkg::ST_SC_RD;
        else state_nxt = cit_pkg::ST_SC_WSQ;
      cit_pkg::ST_SC_WSQ: if (!su_busy) state_nxt = cit_pkg::ST_SC_WDV;
      cit_pkg::ST_SC_WDV:
        if (!su_busy && !su_div)
          state_nxt = (idx_inc == count_r) ? cit_pkg::ST_MT_RD : cit_pkg::ST_SC_RD;
      cit_pkg::ST_MT_RD:  state_nxt = cit_pkg::ST_MT_CHK;
      cit_pkg::ST_MT_CHK:
        if (idx_inc == count_r) begin
          state_nxt = (match || mcnt_r != '0) ? cit_pkg::ST_OBS_OUT : cit_pkg::ST_APPEND;
        end else state_nxt = cit_pkg::ST_MT_RD;
      cit_pkg::ST_APPEND: state_nxt = cit_pkg::ST_OBS_OUT;
      cit_pkg::ST_OBS_OUT: if (!ov_r) state_nxt = cit_pkg::ST_IDLE;
      cit_pkg::ST_CP_RD:  state_nxt = cit_pkg::ST_CP_WR;
      cit_pkg::ST_CP_WR:
        if (idx_inc == count_r) begin
          state_nxt = (kept_nxt == '0) ? cit_pkg::ST_EMPTY_OUT : cit_pkg::ST_LS_RD;
        end else state_nxt = cit_pkg::ST_CP_RD;
      cit_pkg::ST_LS_RD:  state_nxt = cit_pkg::ST_LS_OUT;
      cit_pkg::ST_LS_OUT:
        if (!ov_r) state_nxt = (idx_inc == count_r) ? cit_pkg::ST_IDLE : cit_pkg::ST_LS_RD;
      cit_pkg::ST_EMPTY_OUT: if (!ov_r) state_nxt = cit_pkg::ST_IDLE;
      default: state_nxt = cit_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    seen_nxt = seen_r; count_nxt = count_r; nid_nxt = nid_r; frame_nxt = frame_r;
    obs_nxt = obs_r; idx_nxt = idx_r; kept_nxt = kept_r; score_nxt = score_r;
    mcnt_nxt = mcnt_r; fid_nxt = fid_r; crowded_nxt = crowded_r;
    su_sqrt = 1'b0; su_div = 1'b0; su_op = d2;
    rd_addr = idx_r[AW-1:0]; wr_en = 1'b0; wr_addr = idx_r[AW-1:0]; wr_data = obs_r;
    ov_nxt = ov_r && !out_ready;
    ok_nxt = ok_r; oid_nxt = oid_r; ox_nxt = ox_r; oy_nxt = oy_r; oz_nxt = oz_r;
    onew_nxt = onew_r; odrop_nxt = odrop_r; olast_nxt = olast_r; ocnt_nxt = ocnt_r;
    case (state_r)
      cit_pkg::ST_IDLE:
        if (in_valid && in_ready) begin
          obs_nxt = '{x: in_pos_x, y: in_pos_y, z: in_pos_z, r: in_red,
                      g: in_green, b: in_blue, ident: 16'd0};
          idx_nxt = '0; score_nxt = '0; mcnt_nxt = '0; fid_nxt = '0; kept_nxt = '0;
          crowded_nxt = (crowd_r == 16'd0);
          if (!in_kind) frame_nxt = 1'b1;
        end
      cit_pkg::ST_SC_SQ: begin
        if (dx == '0 || dz == '0) begin
          idx_nxt = idx_inc;
          if (idx_inc == count_r) begin
            idx_nxt = '0;
            crowded_nxt = score_r[15:0] >= crowd_r;
          end
        end else su_sqrt = 1'b1;
      end
      cit_pkg::ST_SC_WSQ:
        if (!su_busy) begin
          su_div = 1'b1;
          su_op = (su_res[16:0] == '0) ? 33'd1 : {16'd0, su_res[16:0]};
        end
      cit_pkg::ST_SC_WDV:
        if (!su_busy) begin
          // A term can reach 2^17 when the distance rounds down to one.
          score_nxt = ({1'b0, score_r} + su_res > 18'(cit_pkg::SCORE_MAX))
                      ? 17'(cit_pkg::SCORE_MAX) : 17'({1'b0, score_r} + su_res);
          idx_nxt = idx_inc;
          if (idx_inc == count_r) begin
            idx_nxt = '0;
            crowded_nxt = score_nxt[15:0] >= crowd_r;
          end
        end
      cit_pkg::ST_MT_CHK: begin
        if (match) begin
          wr_en = 1'b1;
          wr_data.ident = rd_q.ident;
          seen_nxt[idx_r[AW-1:0]] = 1'b1;
          if (mcnt_r == '0) fid_nxt = rd_q.ident;
          if (mcnt_r != 5'd31) mcnt_nxt = mcnt_r + 5'd1;
        end
        idx_nxt = idx_inc;
      end
      cit_pkg::ST_APPEND: begin
        if (count_r != MAXC) begin
          wr_en = 1'b1; wr_addr = count_r[AW-1:0]; wr_data.ident = nid_r;
          seen_nxt[count_r[AW-1:0]] = 1'b1;
          count_nxt = count_r + CW'(1); nid_nxt = nid_r + 16'd1; fid_nxt = nid_r;
        end
      end
      cit_pkg::ST_OBS_OUT:
        if (!ov_r) begin
          ov_nxt = 1'b1; ok_nxt = cit_pkg::RK_OBS; ox_nxt = obs_r.x; oy_nxt = obs_r.y;
          oz_nxt = obs_r.z; ocnt_nxt = mcnt_r; olast_nxt = 1'b1;
          onew_nxt = appended_r;
          odrop_nxt = dropped_r;
          oid_nxt = dropped_r ? 16'd0 : fid_r;
        end
      cit_pkg::ST_CP_WR: begin
        if (seen_r[idx_r[AW-1:0]]) begin
          wr_en = 1'b1; wr_addr = kept_r[AW-1:0]; wr_data = rd_q;
          kept_nxt = kept_r + CW'(1);
        end
        idx_nxt = idx_inc;
        if (idx_inc == count_r) begin
          seen_nxt = '0; frame_nxt = 1'b0; count_nxt = kept_nxt; idx_nxt = '0;
        end
      end
      cit_pkg::ST_LS_OUT:
        if (!ov_r) begin
          ov_nxt = 1'b1; ok_nxt = cit_pkg::RK_ENTRY; oid_nxt = rd_q.ident;
          ox_nxt = rd_q.x; oy_nxt = rd_q.y; oz_nxt = rd_q.z; onew_nxt = 1'b0;
          ocnt_nxt = '0; odrop_nxt = 1'b0; olast_nxt = (idx_inc == count_r);
          idx_nxt = idx_inc;
        end
      cit_pkg::ST_EMPTY_OUT:
        if (!ov_r) begin
          ov_nxt = 1'b1; ok_nxt = cit_pkg::RK_EMPTY; oid_nxt = '0; ox_nxt = '0;
          oy_nxt = '0; oz_nxt = '0; onew_nxt = 1'b0; ocnt_nxt = '0; odrop_nxt = 1'b0;
          olast_nxt = 1'b1;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cit_pkg::ST_IDLE;
      near_r <= 16'd102; tight_r <= 16'd51; crowd_r <= 16'd51; color_r <= 24'd76800;
      seen_r <= '0; count_r <= '0; nid_r <= '0; frame_r <= 1'b0; ov_r <= 1'b0;
      appended_r <= 1'b0; dropped_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seen_r <= seen_nxt; count_r <= count_nxt; nid_r <= nid_nxt; frame_r <= frame_nxt;
      ov_r <= ov_nxt;
      if (state_r == cit_pkg::ST_IDLE) begin
        appended_r <= 1'b0; dropped_r <= 1'b0;
      end else if (state_r == cit_pkg::ST_APPEND) begin
        appended_r <= (count_r != MAXC); dropped_r <= (count_r == MAXC);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cit_pkg::CFG_NEAR:  near_r  <= cfg_data[15:0];
          cit_pkg::CFG_TIGHT: tight_r <= cfg_data[15:0];
          cit_pkg::CFG_CROWD: crowd_r <= cfg_data[15:0];
          cit_pkg::CFG_COLOR: color_r <= cfg_data;
          default: ;
        endcase
      end
    end
    obs_r <= obs_nxt; idx_r <= idx_nxt; kept_r <= kept_nxt; score_r <= score_nxt;
    mcnt_r <= mcnt_nxt; fid_r <= fid_nxt; crowded_r <= crowded_nxt;
    ok_r <= ok_nxt; oid_r <= oid_nxt; ox_r <= ox_nxt; oy_r <= oy_nxt; oz_r <= oz_nxt;
    ocnt_r <= ocnt_nxt; olast_r <= olast_nxt; odrop_r <= odrop_nxt;
    onew_r <= onew_nxt;
  end

  assign out_valid = ov_r;
  assign out_result_kind = ok_r;
  assign out_person_id = oid_r;
  assign out_out_x = ox_r;
  assign out_out_y = oy_r;
  assign out_out_z = oz_r;
  assign out_is_new = onew_r;
  assign out_match_count = ocnt_r;
  assign out_dropped = odrop_r;
  assign out_last = olast_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAXC) else $error("entry count beyond table size");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != cit_pkg::ST_IDLE) |-> !in_ready) else $error("ready while busy");
  a_new_not_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_new && out_dropped)) else $error("new and dropped together");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == cit_pkg::RK_EMPTY) |-> (out_person_id == '0 && out_last))
    else $error("empty marker malformed");
`endif
endmodule
`default_nettype wire

>>> hdl/cit_seq_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared bit-serial unit: square root of a 33-bit value (two bits per step) or
// restoring division of TERM_NUM by a 17-bit divisor (one bit per step).
module cit_seq_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start_sqrt,
  input  wire logic        start_div,
  input  wire logic [32:0] operand,
  output logic             busy,
  output logic [17:0]      result
);
  localparam logic [17:0] TERM_NUM_EXT = cit_pkg::TERM_NUM;

  logic [33:0] rem_r, rem_nxt;
  logic [33:0] val_r, val_nxt;
  logic [17:0] res_r, res_nxt;
  logic [16:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        mode_r, mode_nxt;
  logic        busy_r, busy_nxt;
  logic [35:0] trial;
  logic [18:0] dtrial;
  logic [35:0] rem_sh;
  logic [18:0] drem;

  always_comb begin
    rem_nxt = rem_r; val_nxt = val_r; res_nxt = res_r; dvs_nxt = dvs_r;
    cnt_nxt = cnt_r; mode_nxt = mode_r; busy_nxt = busy_r;
    rem_sh = {rem_r, val_r[33:32]};
    trial = rem_sh - {16'd0, res_r, 2'b01};
    drem = {rem_r[17:0], val_r[33]};
    dtrial = drem - {2'b00, dvs_r};
    if (start_sqrt) begin
      val_nxt = {1'b0, operand}; rem_nxt = '0; res_nxt = '0;
      cnt_nxt = 5'd17; mode_nxt = 1'b0; busy_nxt = 1'b1;
    end else if (start_div) begin
      val_nxt = {TERM_NUM_EXT, 16'd0}; rem_nxt = '0; res_nxt = '0;
      dvs_nxt = operand[16:0]; cnt_nxt = 5'd18; mode_nxt = 1'b1; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!mode_r) begin
        val_nxt = {val_r[31:0], 2'b00};
        if (!trial[35]) begin
          rem_nxt = trial[33:0]; res_nxt = {res_r[16:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[33:0]; res_nxt = {res_r[16:0], 1'b0};
        end
      end else begin
        val_nxt = {val_r[32:0], 1'b0};
        if (!dtrial[18]) begin
          rem_nxt = {16'd0, dtrial[17:0]}; res_nxt = {res_r[16:0], 1'b1};
        end else begin
          rem_nxt = {15'd0, drem}; res_nxt = {res_r[16:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt; val_r <= val_nxt; res_r <= res_nxt;
    dvs_r <= dvs_nxt; mode_r <= mode_nxt;
  end

  assign busy = busy_r;
  assign result = res_r;
endmodule
`default_nettype wire

>>> dv/tb_cluster_identity_tracker.sv
`timescale 1ns / 1ps
module tb_cluster_identity_tracker;
  localparam int TABLE_DEPTH = 16;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [1:0]  rk;
    logic [15:0] id;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        nw;
    logic [4:0]  mc;
    logic        dr;
    logic        lt;
  } track_res_t;

  typedef struct {
    bit          kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [11:0] r;
    logic [11:0] g;
    logic [11:0] b;
    bit          typed_empty;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [15:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [11:0] in_red = '0, in_green = '0, in_blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_result_kind;
  logic [15:0] out_person_id, out_out_x, out_out_y, out_out_z;
  logic out_is_new;
  logic [4:0] out_match_count;
  logic out_dropped, out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  cluster_identity_tracker #(.MAX_ENTRIES(TABLE_DEPTH)) uut (.*);

  always #10 clk = ~clk;

  // Predictor state: a private copy of the object table and registers.
  logic signed [15:0] trk_x[TABLE_DEPTH], trk_z[TABLE_DEPTH];
  logic [15:0] trk_y[TABLE_DEPTH], trk_id[TABLE_DEPTH];
  logic [11:0] trk_r[TABLE_DEPTH], trk_g[TABLE_DEPTH], trk_b[TABLE_DEPTH];
  bit trk_seen[TABLE_DEPTH];
  int trk_count = 0;
  logic [15:0] trk_next_id = '0;
  bit trk_had_obs = 0;
  longint unsigned reg_near = 102, reg_tight = 51, reg_crowd = 51, reg_color = 76800;

  track_res_t pending_results[$];
  int errors = 0;
  longint cycles = 0;
  bit calm = 0;
  int stall_left = 0;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic track_res_t mk_res(logic [1:0] rk, logic [15:0] id, logic [15:0] x,
                                        logic [15:0] y, logic [15:0] z, logic nw,
                                        logic [4:0] mc, logic dr, logic lt);
    track_res_t t;
    t.rk = rk; t.id = id; t.x = x; t.y = y; t.z = z;
    t.nw = nw; t.mc = mc; t.dr = dr; t.lt = lt;
    return t;
  endfunction

  function automatic void queue_expect(track_res_t t);
    pending_results.insert(pending_results.size(), t);
  endfunction

  task automatic track_step(input bit kind, input logic signed [15:0] px,
                            input logic [15:0] py, input logic signed [15:0] pz,
                            input logic [11:0] cr, input logic [11:0] cg,
                            input logic [11:0] cb);
    longint dx, dz, t;
    longint unsigned d2, d, score, r2, cd;
    bit crowded, hit;
    int hits, kept;
    logic [15:0] first_id;
    if (!kind) begin
      trk_had_obs = 1;
      score = 0;
      hits = 0;
      first_id = '0;
      for (int i = 0; i < trk_count; i++) begin
        dx = longint'(px) - longint'(trk_x[i]);
        dz = longint'(pz) - longint'(trk_z[i]);
        if (dx != 0 && dz != 0) begin
          d = floor_sqrt(dx * dx + dz * dz);
          if (d == 0) d = 1;
          score += 131072 / d;
          if (score > 65535) score = 65535;
        end
      end
      crowded = score >= reg_crowd;
      r2 = crowded ? reg_tight * reg_tight : reg_near * reg_near;
      for (int i = 0; i < trk_count; i++) begin
        dx = longint'(px) - longint'(trk_x[i]);
        dz = longint'(pz) - longint'(trk_z[i]);
        d2 = dx * dx + dz * dz;
        hit = d2 < r2;
        if (hit && crowded) begin
          t = longint'(cr) - longint'(trk_r[i]);
          cd = t * t;
          t = longint'(cg) - longint'(trk_g[i]);
          cd += t * t;
          t = longint'(cb) - longint'(trk_b[i]);
          cd += t * t;
          hit = cd < reg_color;
        end
        if (hit) begin
          if (hits == 0) first_id = trk_id[i];
          trk_x[i] = px; trk_y[i] = py; trk_z[i] = pz;
          trk_r[i] = cr; trk_g[i] = cg; trk_b[i] = cb;
          trk_seen[i] = 1;
          hits++;
        end
      end
      if (hits > 0) begin
        queue_expect(mk_res(cit_pkg::RK_OBS, first_id, px, py, pz, 0,
                            (hits > 31) ? 5'd31 : 5'(hits), 0, 1));
      end else if (trk_count < TABLE_DEPTH) begin
        trk_x[trk_count] = px; trk_y[trk_count] = py; trk_z[trk_count] = pz;
        trk_r[trk_count] = cr; trk_g[trk_count] = cg; trk_b[trk_count] = cb;
        trk_id[trk_count] = trk_next_id;
        trk_seen[trk_count] = 1;
        trk_count++;
        queue_expect(mk_res(cit_pkg::RK_OBS, trk_next_id, px, py, pz, 1, 0, 0, 1));
        trk_next_id = trk_next_id + 16'd1;
      end else begin
        queue_expect(mk_res(cit_pkg::RK_OBS, '0, px, py, pz, 0, 0, 1, 1));
      end
    end else if (!trk_had_obs) begin
      queue_expect(mk_res(cit_pkg::RK_EMPTY, '0, '0, '0, '0, 0, 0, 0, 1));
    end else begin
      trk_had_obs = 0;
      kept = 0;
      for (int i = 0; i < trk_count; i++) begin
        if (trk_seen[i]) begin
          trk_x[kept] = trk_x[i]; trk_y[kept] = trk_y[i]; trk_z[kept] = trk_z[i];
          trk_r[kept] = trk_r[i]; trk_g[kept] = trk_g[i]; trk_b[kept] = trk_b[i];
          trk_id[kept] = trk_id[i];
          trk_seen[kept] = 0;
          kept++;
        end
      end
      for (int i = kept; i < TABLE_DEPTH; i++) trk_seen[i] = 0;
      trk_count = kept;
      if (kept == 0) begin
        queue_expect(mk_res(cit_pkg::RK_EMPTY, '0, '0, '0, '0, 0, 0, 0, 1));
      end
      for (int i = 0; i < kept; i++) begin
        queue_expect(mk_res(cit_pkg::RK_ENTRY, trk_id[i], trk_x[i], trk_y[i],
                            trk_z[i], 0, 0, 0, (i + 1 == kept)));
      end
    end
  endtask

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_item(input stim_row_t s);
    int depth;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= s.kind;
    in_pos_x <= s.x; in_pos_y <= s.y; in_pos_z <= s.z;
    in_red <= s.r; in_green <= s.g; in_blue <= s.b;
    do @(posedge clk); while (!(in_valid && in_ready));
    depth = pending_results.size();
    track_step(s.kind, s.x, s.y, s.z, s.r, s.g, s.b);
    if (s.typed_empty) begin
      while (pending_results.size() > depth) void'(pending_results.pop_back());
      queue_expect(mk_res(cit_pkg::RK_EMPTY, '0, '0, '0, '0, 0, 0, 0, 1));
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      cit_pkg::CFG_NEAR:  reg_near = data[15:0];
      cit_pkg::CFG_TIGHT: reg_tight = data[15:0];
      cit_pkg::CFG_CROWD: reg_crowd = data[15:0];
      cit_pkg::CFG_COLOR: reg_color = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic settle_and_configure(input logic [15:0] nr, input logic [15:0] tr,
                                      input logic [15:0] cl, input logic [23:0] co);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    write_reg(cit_pkg::CFG_NEAR, {8'd0, nr});
    write_reg(cit_pkg::CFG_TIGHT, {8'd0, tr});
    write_reg(cit_pkg::CFG_CROWD, {8'd0, cl});
    write_reg(cit_pkg::CFG_COLOR, co);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic stim_row_t row(bit k, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                    logic [11:0] r, logic [11:0] g, logic [11:0] b,
                                    bit te = 0);
    stim_row_t s;
    s.kind = k; s.x = x; s.y = y; s.z = z; s.r = r; s.g = g; s.b = b;
    s.typed_empty = te;
    return s;
  endfunction

  function automatic logic [11:0] near_color(int c);
    c = c + $urandom_range(0, 64) - 32;
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return 12'(c);
  endfunction

  // Receiver side: bursts of back-pressure.
  always @(negedge clk) begin
    if (calm || !rst_n) begin
      out_ready <= rst_n;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    track_res_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("tb_cluster_identity_tracker failed");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, kind %0d id %h", $time, out_result_kind,
                 out_person_id);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", want.rk, out_result_kind);
        check_field("person_id", want.id, out_person_id);
        check_field("out_x", want.x, out_out_x);
        check_field("out_y", want.y, out_out_y);
        check_field("out_z", want.z, out_out_z);
        check_field("is_new", want.nw, out_is_new);
        check_field("match_count", want.mc, out_match_count);
        check_field("dropped", want.dr, out_dropped);
        check_field("last", want.lt, out_last);
      end
    end
  end

  initial begin
    stim_row_t plan[$];
    int ax[6], ay[6], az[6], ar[6], ag[6], ab[6];
    int span, nobs, k, sent;
    logic [15:0] nr, tr, cl;
    logic [23:0] co;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: quiet frame first, then fill the table past its depth.
    plan.insert(plan.size(), row(1, 0, 0, 0, 0, 0, 0, 1));
    for (int i = 0; i < 16; i++) begin
      plan.insert(plan.size(),
                  row(0, 16'(-32768 + i * 4096), 16'(i * 4369), 16'(32767 - i * 4000),
                      12'(i * 273), 12'(4095 - i * 273), 12'(i * 100)));
    end
    plan.insert(plan.size(), row(0, 16'd2048, 16'hFFFF, 16'd2048, 12'hFFF, 12'd0, 12'hFFF));
    plan.insert(plan.size(), row(1, 0, 0, 0, 0, 0, 0));
    // An observation that matches nothing on a full table, so no entry survives.
    plan.insert(plan.size(), row(0, 16'h7FFF, 16'h8000, 16'h7FFF, 12'd0, 12'hFFF, 12'd0));
    plan.insert(plan.size(), row(1, 0, 0, 0, 0, 0, 0, 1));
    plan.insert(plan.size(), row(0, 16'h7FFF, 16'h7FFF, 16'h8000, 12'hFFF, 12'hFFF, 12'hFFF));
    plan.insert(plan.size(), row(0, 16'h7FFF, 16'h0000, 16'h8000, 12'hFFF, 12'hFFF, 12'hFFF));
    plan.insert(plan.size(), row(1, 0, 0, 0, 0, 0, 0));
    foreach (plan[i]) send_item(plan[i]);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin nr = 300; tr = 120; cl = 200; co = 20000; end
        1: begin nr = 0; tr = 0; cl = 0; co = 0; end
        2: begin nr = 16'hFFFF; tr = 16'hFFFF; cl = 16'hFFFF; co = 24'hFFFFFF; end
        3: begin
          nr = 16'($urandom_range(0, 2000)); tr = 16'($urandom_range(0, 1000));
          cl = 16'($urandom); co = 24'($urandom);
        end
        default: begin nr = 102; tr = 51; cl = 51; co = 76800; end
      endcase
      settle_and_configure(nr, tr, cl, co);
      if (phase == 4) calm = 1;
      span = $urandom_range(300, 30000);
      for (int j = 0; j < 6; j++) begin
        ax[j] = $urandom_range(0, 2 * span) - span;
        az[j] = $urandom_range(0, 2 * span) - span;
        ay[j] = $urandom_range(0, 65535);
        ar[j] = $urandom_range(0, 4095);
        ag[j] = $urandom_range(0, 4095);
        ab[j] = $urandom_range(0, 4095);
      end
      sent = 0;
      while (sent < 62) begin
        nobs = $urandom_range(0, 5);
        for (int j = 0; j < nobs; j++) begin
          if ($urandom_range(0, 7) == 0) begin
            send_item(row(0, 16'($urandom), 16'($urandom), 16'($urandom),
                          12'($urandom), 12'($urandom), 12'($urandom)));
          end else begin
            k = $urandom_range(0, 5);
            ax[k] += $urandom_range(0, 40) - 20;
            az[k] += $urandom_range(0, 40) - 20;
            send_item(row(0, 16'(ax[k] + $urandom_range(0, 60) - 30), 16'(ay[k]),
                          16'(az[k] + $urandom_range(0, 60) - 30), near_color(ar[k]),
                          near_color(ag[k]), near_color(ab[k])));
          end
        end
        send_item(row(1, 16'($urandom), 16'($urandom), 16'($urandom),
                      12'($urandom), 12'($urandom), 12'($urandom)));
        if ($urandom_range(0, 9) == 0) send_item(row(1, 0, 0, 0, 0, 0, 0));
        sent += nobs + 1;
        // In phase 0, hold off the sender until the block has drained whenever the sent count lies in 31 to 36.
        if (phase == 0 && sent > 30 && sent <= 36) begin
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("tb_cluster_identity_tracker passed");
    end else begin
      $display("tb_cluster_identity_tracker failed");
    end
    $finish;
  end
endmodule
